// ----- rtl/rr_heart_rate_averager_macros.svh -----
// Assertion macros shared by the heart rate averager checker.
`ifndef RR_HEART_RATE_AVERAGER_MACROS_SVH
`define RR_HEART_RATE_AVERAGER_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define RRHR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Clocked assertion that also holds during reset.
`define RRHR_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

// ----- rtl/rrhr_pkg.sv -----
// Package: types and constants of the heart rate averager.
`default_nettype none

package rrhr_pkg;

   // Field widths
   localparam int POS_W     = 32;
   localparam int RATE_W    = 16;
   localparam int SR_W      = 13;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;

   // 60 * samp_freq fits in 19 bits for any 13-bit sample rate
   localparam int RATE_SCALE = 60;
   localparam int NUM_W      = 19;

   localparam logic [RATE_W-1:0] RATE_MAX = 16'hFFFF;

   // Plausibility window 0.7 .. 1.4 of the mean, tested as 7*m <= 10*r <= 14*m
   localparam int GATE_W        = 20;
   localparam int GATE_RATE_MUL = 10;
   localparam int GATE_LO_MUL   = 7;
   localparam int GATE_HI_MUL   = 14;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SAMP_FREQ = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RATE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE  = 2'd2;

   // Register reset values
   localparam logic [SR_W-1:0]   SAMP_FREQ_RST = 13'd360;
   localparam logic [RATE_W-1:0] MIN_RATE_RST  = 16'd40;
   localparam logic [RATE_W-1:0] MAX_RATE_RST  = 16'd201;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RATE_START,
      ST_RATE_WAIT,
      ST_UPDATE,
      ST_SUM,
      ST_AVG_START,
      ST_AVG_WAIT,
      ST_DONE
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_in;
      logic div_start;
      logic div_sel_avg;
      logic update;
      logic sum_step;
      logic mean_zero;
      logic mean_load;
      logic out_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic beat_ok;
      logic div_done;
      logic sum_last;
      logic all_zero;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/rrhr_if.sv -----
// Interfaces: beat position request channel and rate response channel.
`default_nettype none

interface rrhr_req_if import rrhr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  current_beat_pos;
   logic [POS_W-1:0]  previous_beat_pos;

   modport source (output valid, output current_beat_pos, output previous_beat_pos,
                   input ready);
   modport sink   (input valid, input current_beat_pos, input previous_beat_pos,
                   output ready);
endinterface

interface rrhr_rsp_if import rrhr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] average_rate;
   logic [RATE_W-1:0] accepted_rate;

   modport source (output valid, output average_rate, output accepted_rate,
                   input ready);
   modport sink   (input valid, input average_rate, input accepted_rate,
                   output ready);
endinterface

`default_nettype wire

// ----- rtl/rrhr_divider.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module rrhr_divider import rrhr_pkg::*; #(
   parameter int DVD_W = 20,
   parameter int DVS_W = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic [DVD_W-1:0]      quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DVS_W:0]   trial;
   logic [DVS_W+1:0] diff;
   logic             take;

   // One trial subtraction
   always_comb begin
      trial = {rem_ff, quo_ff[DVD_W-1]};
      diff  = {1'b0, trial} - {2'b00, dvs_ff};
      take  = !diff[DVS_W+1];
   end

   // Next values
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], take};
         rem_in = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Operand registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ----- rtl/rrhr_datapath.sv -----
// Datapath: registers, rate and average arithmetic, history, output stage.
`default_nettype none

module rrhr_datapath import rrhr_pkg::*; #(
   parameter int HISTORY_LEN = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output status_type                status,
   input  wire logic [POS_W-1:0]     current_beat_pos,
   input  wire logic [POS_W-1:0]     previous_beat_pos,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   output logic [RATE_W-1:0]         average_rate,
   output logic [RATE_W-1:0]         accepted_rate
);

   localparam int IDX_W = $clog2(HISTORY_LEN);
   localparam int ZW    = $clog2(HISTORY_LEN + 1);
   localparam int SUM_W = RATE_W + $clog2(HISTORY_LEN);
   localparam int DVD_W = (SUM_W > NUM_W) ? SUM_W : NUM_W;

   // Configuration registers
   logic [SR_W-1:0]   samp_freq_ff, samp_freq_in;
   logic [RATE_W-1:0] min_rate_ff, min_rate_in;
   logic [RATE_W-1:0] max_rate_ff, max_rate_in;

   // Item and state registers
   logic [POS_W-1:0]  cur_ff, cur_in;
   logic [POS_W-1:0]  prev_ff, prev_in;
   logic [RATE_W-1:0] hist_ff [HISTORY_LEN];
   logic [RATE_W-1:0] hist_in [HISTORY_LEN];
   logic [RATE_W-1:0] last_acc_ff, last_acc_in;
   logic [RATE_W-1:0] mean_ff, mean_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;

   // Output stage
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RATE_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic [RATE_W-1:0] rsp_acc_ff, rsp_acc_in;

   logic [POS_W-1:0]  interval;
   logic [NUM_W-1:0]  rate_num;
   logic [DVD_W-1:0]  div_dividend;
   logic [POS_W-1:0]  div_divisor;
   logic [DVD_W-1:0]  div_quotient;
   logic              div_done;
   logic [RATE_W-1:0] rate_sat;
   logic [GATE_W-1:0] rate_x10, mean_lo, mean_hi;
   logic              gate_pass;
   logic [RATE_W-1:0] new_acc;
   logic [ZW-1:0]     zero_cnt;
   logic [ZW-1:0]     avg_count;
   logic [RATE_W-1:0] hist_sel;

   // Interval and rate numerator
   always_comb begin
      interval = cur_ff - prev_ff;
      rate_num = NUM_W'(samp_freq_ff) * NUM_W'(RATE_SCALE);
   end

   // Count of zero entries and number of entries averaged
   always_comb begin
      zero_cnt = '0;
      for (int i = 0; i < HISTORY_LEN; i++) begin
         if (hist_ff[i] == '0) zero_cnt = zero_cnt + ZW'(1);
      end
      avg_count = ZW'(HISTORY_LEN) - zero_cnt;
   end

   // Shared divider operands
   always_comb begin
      if (cmd.div_sel_avg) begin
         div_dividend = DVD_W'(sum_ff);
         div_divisor  = POS_W'(avg_count);
      end else begin
         div_dividend = DVD_W'(rate_num);
         div_divisor  = interval;
      end
   end

   rrhr_divider #(
      .DVD_W (DVD_W),
      .DVS_W (POS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Saturated instant rate and plausibility gate
   always_comb begin
      rate_sat  = (div_quotient > DVD_W'(RATE_MAX)) ? RATE_MAX : div_quotient[RATE_W-1:0];
      rate_x10  = GATE_W'(rate_sat) * GATE_W'(GATE_RATE_MUL);
      mean_lo   = GATE_W'(mean_ff) * GATE_W'(GATE_LO_MUL);
      mean_hi   = GATE_W'(mean_ff) * GATE_W'(GATE_HI_MUL);
      gate_pass = (last_acc_ff == '0)
               || ((mean_lo <= rate_x10) && (rate_x10 <= mean_hi))
               || (mean_ff == '0)
               || ((rate_sat >= min_rate_ff) && (rate_sat <= max_rate_ff));
      new_acc   = gate_pass ? rate_sat : last_acc_ff;
   end

   assign hist_sel = hist_ff[idx_ff];

   // Next values of the datapath registers
   always_comb begin
      samp_freq_in = samp_freq_ff;
      min_rate_in  = min_rate_ff;
      max_rate_in  = max_rate_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      hist_in      = hist_ff;
      last_acc_in  = last_acc_ff;
      mean_in      = mean_ff;
      sum_in       = sum_ff;
      idx_in       = idx_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_SAMP_FREQ: samp_freq_in = csr_wdata[SR_W-1:0];
            CSR_MIN_RATE:  min_rate_in  = csr_wdata[RATE_W-1:0];
            CSR_MAX_RATE:  max_rate_in  = csr_wdata[RATE_W-1:0];
            default:       samp_freq_in = samp_freq_ff;
         endcase
      end

      if (cmd.load_in) begin
         cur_in  = current_beat_pos;
         prev_in = previous_beat_pos;
      end

      // Gate the rate and shift it into the history
      if (cmd.update) begin
         last_acc_in = new_acc;
         for (int i = 0; i < HISTORY_LEN - 1; i++) hist_in[i] = hist_ff[i + 1];
         hist_in[HISTORY_LEN-1] = new_acc;
         sum_in = '0;
         idx_in = '0;
      end

      // Sum entries from the first counted index upward, one per cycle
      if (cmd.sum_step) begin
         if (ZW'(idx_ff) >= zero_cnt) sum_in = sum_ff + SUM_W'(hist_sel);
         if (!status.sum_last) idx_in = idx_ff + IDX_W'(1);
      end

      if (cmd.mean_zero) mean_in = '0;
      else if (cmd.mean_load) mean_in = div_quotient[RATE_W-1:0];
   end

   // Output stage next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_acc_in   = rsp_acc_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_avg_in   = mean_ff;
         rsp_acc_in   = last_acc_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Registers with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         samp_freq_ff <= SAMP_FREQ_RST;
         min_rate_ff  <= MIN_RATE_RST;
         max_rate_ff  <= MAX_RATE_RST;
         for (int i = 0; i < HISTORY_LEN; i++) hist_ff[i] <= '0;
         last_acc_ff  <= '0;
         mean_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         samp_freq_ff <= samp_freq_in;
         min_rate_ff  <= min_rate_in;
         max_rate_ff  <= max_rate_in;
         hist_ff      <= hist_in;
         last_acc_ff  <= last_acc_in;
         mean_ff      <= mean_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      sum_ff     <= sum_in;
      idx_ff     <= idx_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_acc_ff <= rsp_acc_in;
   end

   // Status to the controller
   always_comb begin
      status.beat_ok  = (cur_ff != '0) && (prev_ff != '0) && (cur_ff > prev_ff);
      status.div_done = div_done;
      status.sum_last = (idx_ff == IDX_W'(HISTORY_LEN - 1));
      status.all_zero = (zero_cnt == ZW'(HISTORY_LEN));
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign average_rate  = rsp_avg_ff;
   assign accepted_rate = rsp_acc_ff;

endmodule

`default_nettype wire

// ----- rtl/rrhr_ctrl.sv -----
// Controller: sequences one item through rate, gate, sum and average.
`default_nettype none

module rrhr_ctrl import rrhr_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_valid) state_in = ST_RATE_START;
         ST_RATE_START: state_in = status.beat_ok ? ST_RATE_WAIT : ST_DONE;
         ST_RATE_WAIT:  if (status.div_done) state_in = ST_UPDATE;
         ST_UPDATE:     state_in = ST_SUM;
         ST_SUM:        if (status.sum_last) state_in = ST_AVG_START;
         ST_AVG_START:  state_in = status.all_zero ? ST_DONE : ST_AVG_WAIT;
         ST_AVG_WAIT:   if (status.div_done) state_in = ST_DONE;
         ST_DONE:       if (status.out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // no item is taken while reset is high
            req_ready   = !reset;
            cmd.load_in = req_valid && !reset;
         end
         ST_RATE_START: begin
            cmd.div_start = status.beat_ok;
            cmd.mean_zero = !status.beat_ok;
         end
         ST_RATE_WAIT: begin
            cmd.div_sel_avg = 1'b0;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_SUM: begin
            cmd.sum_step = 1'b1;
         end
         ST_AVG_START: begin
            cmd.div_sel_avg = 1'b1;
            cmd.div_start   = !status.all_zero;
            cmd.mean_zero   = status.all_zero;
         end
         ST_AVG_WAIT: begin
            cmd.div_sel_avg = 1'b1;
            cmd.mean_load   = status.div_done;
         end
         ST_DONE: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/rr_heart_rate_averager.sv -----
// Top level: heart rate from beat positions with a moving average.
//
//   channel | direction | handshake          | payload
//   req_ch  | in        | valid / ready      | current_beat_pos, previous_beat_pos
//   rsp_ch  | out       | valid / ready      | average_rate, accepted_rate
//   csr_*   | in        | csr_we, no stall   | csr_index, csr_wdata
//
// Each item runs through the shared one-bit-per-cycle divider, used for the rate
// and then for the average; its dividend is max(19, 16 + clog2(HISTORY_LEN)) bits.
// The average divide is skipped when the history holds only zeros, and both divides
// are skipped for a missing beat.
// One item at a time; the next is taken while a result waits in the output register.
// Reset is synchronous and clears the history, rates and output valid.
`default_nettype none

module rr_heart_rate_averager import rrhr_pkg::*; #(
   parameter int HISTORY_LEN = 5
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   rrhr_req_if.sink                  req_ch,
   rrhr_rsp_if.source                rsp_ch,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   rrhr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rrhr_datapath #(
      .HISTORY_LEN (HISTORY_LEN)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .current_beat_pos  (req_ch.current_beat_pos),
      .previous_beat_pos (req_ch.previous_beat_pos),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .average_rate      (rsp_ch.average_rate),
      .accepted_rate     (rsp_ch.accepted_rate)
   );

endmodule

`default_nettype wire

// ----- rtl/rr_heart_rate_averager_checker.sv -----
// Checker on the top-level ports of the heart rate averager, with its bind.
`default_nettype none
`include "rr_heart_rate_averager_macros.svh"

module rrhr_checker import rrhr_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [RATE_W-1:0] average_rate,
   input wire logic [RATE_W-1:0] accepted_rate
);

   // Output stage is empty after reset
   `RRHR_ASSERT_RST(a_rsp_idle_after_reset, reset |=> !rsp_valid, "rsp valid after reset")

   // One item at a time: no second item right after an accept
   `RRHR_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "ready after accept")

   // A stalled result holds
   `RRHR_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(average_rate) && $stable(accepted_rate), "stalled result changed")

endmodule

bind rr_heart_rate_averager rrhr_checker u_rrhr_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .average_rate  (rsp_ch.average_rate),
   .accepted_rate (rsp_ch.accepted_rate)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the heart rate averager: directed and random beats, checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
   import rrhr_pkg::*;

   localparam int HIST_DEPTH = 5;
   localparam int BPM_SCALE = 60;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int TAIL_CYCLES = 64;
   localparam longint TIMEOUT_NS = 64'd20_000_000;

   typedef struct packed {
      logic [RATE_W-1:0] average_rate;
      logic [RATE_W-1:0] accepted_rate;
   } rate_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   rrhr_req_if req_ch ();
   rrhr_rsp_if rsp_ch ();

   rr_heart_rate_averager #(.HISTORY_LEN(HIST_DEPTH)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor state and its copy of the registers
   logic [RATE_W-1:0] rate_hist [HIST_DEPTH];
   logic [RATE_W-1:0] held_rate;
   logic [RATE_W-1:0] mean_bpm;
   logic [SR_W-1:0] cfg_samp_freq = SAMP_FREQ_RST;
   logic [RATE_W-1:0] cfg_min_rate = MIN_RATE_RST;
   logic [RATE_W-1:0] cfg_max_rate = MAX_RATE_RST;

   rate_result_type due_rates [$];
   rate_result_type want_rates;
   int unsigned fail_count = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   // Clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Advance the predictor by one beat item and return the rates it should report
   function automatic rate_result_type next_rates(input logic [POS_W-1:0] cur,
                                                  input logic [POS_W-1:0] prev);
      logic [63:0] interval;
      logic [63:0] quotient;
      logic [63:0] rate_x10;
      logic [63:0] win_lo;
      logic [63:0] win_hi;
      logic [RATE_W-1:0] inst;
      logic [31:0] total;
      int unsigned zeros;
      rate_result_type res;
      if (cur != 0 && prev != 0 && cur > prev) begin
         interval = 64'(cur - prev);
         quotient = (64'(BPM_SCALE) * 64'(cfg_samp_freq)) / interval;
         inst = (quotient > 64'hFFFF) ? 16'hFFFF : quotient[RATE_W-1:0];
         rate_x10 = 64'd10 * 64'(inst);
         win_lo = 64'd7 * 64'(mean_bpm);
         win_hi = 64'd14 * 64'(mean_bpm);
         // plausibility gate: any one of four conditions lets the rate through
         if (held_rate == 0 || (win_lo <= rate_x10 && rate_x10 <= win_hi) || mean_bpm == 0 ||
             (inst >= cfg_min_rate && inst <= cfg_max_rate)) begin
            held_rate = inst;
         end
         for (int i = 0; i < HIST_DEPTH - 1; i++) rate_hist[i] = rate_hist[i+1];
         rate_hist[HIST_DEPTH-1] = held_rate;
         // average from the first index past the zero count, zeros inside included
         zeros = 0;
         for (int i = 0; i < HIST_DEPTH; i++) if (rate_hist[i] == 0) zeros++;
         if (zeros >= HIST_DEPTH) begin
            mean_bpm = '0;
         end else begin
            total = 0;
            for (int i = zeros; i < HIST_DEPTH; i++) total += 32'(rate_hist[i]);
            mean_bpm = RATE_W'(total / (HIST_DEPTH - zeros));
         end
      end else begin
         mean_bpm = '0;
      end
      res.average_rate = mean_bpm;
      res.accepted_rate = held_rate;
      return res;
   endfunction

   // Result checker and receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (due_rates.size() == 0) begin
            $display("%0t: result with none pending: average_rate %0d accepted_rate %0d",
                     $time, rsp_ch.average_rate, rsp_ch.accepted_rate);
            fail_count++;
         end else begin
            want_rates = due_rates.pop_front();
            if (rsp_ch.average_rate !== want_rates.average_rate) begin
               $display("%0t: average_rate expected %0d, got %0d", $time,
                        want_rates.average_rate, rsp_ch.average_rate);
               fail_count++;
            end
            if (rsp_ch.accepted_rate !== want_rates.accepted_rate) begin
               $display("%0t: accepted_rate expected %0d, got %0d", $time,
                        want_rates.accepted_rate, rsp_ch.accepted_rate);
               fail_count++;
            end
         end
      end
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Send one beat item; valid stays high into the next item unless the sender idles
   task automatic send_beat(input logic [POS_W-1:0] cur, input logic [POS_W-1:0] prev);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid <= 1'b1;
      req_ch.current_beat_pos <= cur;
      req_ch.previous_beat_pos <= prev;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      due_rates.push_back(next_rates(cur, prev));
   endtask

   // Hold off the sender until every pending result is back
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (due_rates.size() != 0);
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Reprogram all registers while idle; the spare index must be ignored
   task automatic program_limits(input logic [SR_W-1:0] sr, input logic [RATE_W-1:0] lo,
                                 input logic [RATE_W-1:0] hi);
      logic [CSR_W-1:0] sr_word;
      wait_for_results();
      sr_word = CSR_W'($urandom);
      sr_word[SR_W-1:0] = sr;
      write_csr(CSR_SPARE, CSR_W'($urandom));
      write_csr(CSR_SAMP_FREQ, sr_word);
      write_csr(CSR_MIN_RATE, lo);
      write_csr(CSR_MAX_RATE, hi);
      csr_we <= 1'b0;
      cfg_samp_freq = sr;
      cfg_min_rate = lo;
      cfg_max_rate = hi;
   endtask

   // Absent beats and intervals that are not positive
   task automatic test_missing_beats();
      send_beat(32'd0, 32'd0);
      send_beat(32'd1000, 32'd0);
      send_beat(32'd0, 32'd1000);
      send_beat(32'd1000, 32'd1000);
      send_beat(32'd1000, 32'd2000);
   endtask

   // Start-up, history fill, gate reject, band accept, restart after a missing beat
   task automatic test_gate_and_history();
      send_beat(32'd1360, 32'd1000);
      send_beat(32'd1720, 32'd1360);
      send_beat(32'd2080, 32'd1720);
      send_beat(32'd2152, 32'd2080);
      send_beat(32'd2296, 32'd2152);
      send_beat(32'd2836, 32'd2296);
      send_beat(32'd0, 32'd2836);
      send_beat(32'd2922, 32'd2836);
   endtask

   // Position fields at their extremes
   task automatic test_field_extremes();
      send_beat(32'hFFFF_FFFF, 32'h0000_0001);
      send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      send_beat(32'h8000_0000, 32'h7FFF_FFFF);
   endtask

   // Saturated rate, zero sample rate with zeros inside the history, inverted band
   task automatic test_config_extremes();
      program_limits(13'd4096, 16'd0, 16'hFFFF);
      send_beat(32'd101, 32'd100);
      send_beat(32'd103, 32'd101);
      program_limits(13'd0, 16'd0, 16'hFFFF);
      send_beat(32'd500, 32'd103);
      send_beat(32'd900, 32'd500);
      program_limits(13'd1, 16'hFFFF, 16'd0);
      send_beat(32'd960, 32'd900);
      send_beat(32'd961, 32'd960);
      send_beat(32'd1021, 32'd961);
      program_limits(SAMP_FREQ_RST, MIN_RATE_RST, MAX_RATE_RST);
   endtask

   task automatic pick_random_limits();
      logic [SR_W-1:0] sr;
      logic [RATE_W-1:0] lo;
      logic [RATE_W-1:0] hi;
      sr = SR_W'($urandom_range(1, 4096));
      lo = RATE_W'($urandom);
      hi = RATE_W'($urandom);
      case ($urandom_range(5))
         0: begin
            sr = SAMP_FREQ_RST;
            lo = MIN_RATE_RST;
            hi = MAX_RATE_RST;
         end
         1: begin
            lo = RATE_W'($urandom_range(20, 70));
            hi = RATE_W'($urandom_range(120, 260));
         end
         2: sr = $urandom_range(1) ? 13'd1 : 13'd4096;
         3: begin
            lo = '0;
            hi = 16'hFFFF;
         end
         4: begin
            lo = 16'hFFFF;
            hi = '0;
         end
         default: if ($urandom_range(3) == 0) sr = '0;
      endcase
      program_limits(sr, lo, hi);
   endtask

   // Beat trains with jitter, broken by outliers, gaps, reversals and noise
   task automatic test_random_traffic(input int unsigned items, input int unsigned sender_pct,
                                      input int unsigned receiver_pct);
      int unsigned sent;
      int unsigned pick;
      logic [POS_W-1:0] beat_pos;
      logic [POS_W-1:0] nominal;
      logic [POS_W-1:0] jitter;
      logic [POS_W-1:0] interval;
      logic [POS_W-1:0] cur;
      logic [POS_W-1:0] prev;
      send_idle_pct = sender_pct;
      rsp_stall_pct = receiver_pct;
      sent = 0;
      while (sent < items) begin
         pick_random_limits();
         if (cfg_samp_freq == 0) nominal = $urandom_range(1, 3000);
         else nominal = (BPM_SCALE * cfg_samp_freq) / $urandom_range(30, 220);
         if (nominal == 0) nominal = 1;
         jitter = nominal / 10 + 1;
         beat_pos = $urandom;
         repeat ($urandom_range(60, 140)) begin
            if (sent >= items) break;
            pick = $urandom_range(99);
            interval = (nominal + $urandom_range(2 * jitter)) - jitter;
            if (interval == 0) interval = 1;
            if (pick < 78) begin
               // regular beat, or an outlier interval
               if (pick >= 70) begin
                  case ($urandom_range(2))
                     0: interval = nominal / 2 + 1;
                     1: interval = nominal * 2;
                     default: interval = $urandom_range(1, 50);
                  endcase
               end
               prev = beat_pos;
               cur = beat_pos + interval;
               beat_pos = cur;
            end else if (pick < 84) begin
               if ($urandom_range(1)) begin
                  cur = '0;
                  prev = beat_pos;
               end else begin
                  cur = beat_pos;
                  prev = '0;
               end
            end else if (pick < 90) begin
               prev = beat_pos;
               cur = beat_pos - $urandom_range(interval);
            end else if (pick < 95) begin
               cur = $urandom;
               prev = $urandom;
            end else begin
               // restart somewhere random with a very short interval
               beat_pos = $urandom;
               prev = beat_pos;
               cur = beat_pos + $urandom_range(1, 8);
               beat_pos = cur;
            end
            send_beat(cur, prev);
            sent++;
         end
      end
   endtask

   // Run limit
   initial begin
      #(TIMEOUT_NS);
      $display("[FAIL] regression broken");
      $finish;
   end

   // Test sequence
   initial begin
      for (int i = 0; i < HIST_DEPTH; i++) rate_hist[i] = '0;
      held_rate = '0;
      mean_bpm = '0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.current_beat_pos = '0;
      req_ch.previous_beat_pos = '0;
      rsp_ch.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_missing_beats();
      test_gate_and_history();
      test_field_extremes();
      test_config_extremes();
      test_random_traffic(670, 32, 80);
      test_random_traffic(670, 80, 32);
      test_random_traffic(670, 0, 0);

      // drain and let the block settle
      req_ch.valid <= 1'b0;
      while (due_rates.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rrhr_pkg.sv
rtl/rrhr_if.sv
rtl/rrhr_divider.sv
rtl/rrhr_datapath.sv
rtl/rrhr_ctrl.sv
rtl/rr_heart_rate_averager.sv
rtl/rr_heart_rate_averager_checker.sv
tb/tb_top.sv
